>>> sv/lat_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the life automaton.
`default_nettype none
package lat_pkg;
	localparam int MAX_WIDTH_D  = 64;
	localparam int MAX_HEIGHT_D = 64;
	localparam int AGE_BITS_D   = 16;

	localparam int ACT_W  = 2;
	localparam int CX_W   = 6;
	localparam int CY_W   = 6;
	localparam int AGE_W  = 16;
	localparam int GEN_W  = 32;
	localparam int CFG_W  = 7;
	localparam int CIDX_W = 1;
	localparam int CNT_W  = 4;

	localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd3;

	localparam logic [CIDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

	localparam logic [CNT_W-1:0] SURVIVE_N = 4'd2;
	localparam logic [CNT_W-1:0] BIRTH_N   = 4'd3;

	typedef struct packed {
		logic rdy;
		logic clr_step;
		logic y_zero;
		logic rd_prev;
		logic rd_cur;
		logic rd_next;
		logic cap_next;
		logic sweep;
		logic drain;
		logic look;
		logic fire;
	} cmd_t;

	typedef struct packed {
		logic             pend;
		logic             clr_last;
		logic             req_valid;
		logic [ACT_W-1:0] req_act;
		logic             x_last;
		logic             y_last;
		logic             out_free;
	} sts_t;
endpackage
`default_nettype wire

>>> sv/lat_if.sv
// Request and response channel interfaces of the life automaton.
`default_nettype none
interface lat_req_if;
	import lat_pkg::*;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [CX_W-1:0]  cell_x;
	logic [CY_W-1:0]  cell_y;
	logic             alive_in;
	modport source(output valid, action, cell_x, cell_y, alive_in, input ready);
	modport sink(input valid, action, cell_x, cell_y, alive_in, output ready);
endinterface

interface lat_rsp_if;
	import lat_pkg::*;
	logic             valid;
	logic             ready;
	logic             cell_alive;
	logic [AGE_W-1:0] cell_age;
	logic [GEN_W-1:0] gen_number;
	modport source(output valid, cell_alive, cell_age, gen_number, input ready);
	modport sink(input valid, cell_alive, cell_age, gen_number, output ready);
endinterface
`default_nettype wire

>>> sv/lat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lat_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/lat_ctrl.sv
// Sequencing state machine: clear pass, generation sweep, cell lookup and response.
`default_nettype none
module lat_ctrl
	import lat_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_ROW0  = 4'd2;
	localparam logic [3:0] S_ROW1  = 4'd3;
	localparam logic [3:0] S_ROW2  = 4'd4;
	localparam logic [3:0] S_ROW3  = 4'd5;
	localparam logic [3:0] S_CELL  = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_LOOK  = 4'd8;
	localparam logic [3:0] S_RESP  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.pend) begin
					state_d = S_CLR;
				end else begin
					cmd.rdy = 1'b1;
					if (sts.req_valid) begin
						case (sts.req_act)
							ACT_CLEAR: state_d = S_CLR;
							ACT_STEP: begin
								cmd.y_zero = 1'b1;
								state_d    = S_ROW0;
							end
							default: state_d = S_LOOK;
						endcase
					end
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = busy_q ? S_LOOK : S_IDLE;
			end
			S_ROW0: begin
				cmd.rd_prev = 1'b1;
				state_d     = S_ROW1;
			end
			S_ROW1: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_ROW2;
			end
			S_ROW2: begin
				cmd.rd_next = 1'b1;
				state_d     = S_ROW3;
			end
			S_ROW3: begin
				cmd.cap_next = 1'b1;
				state_d      = S_CELL;
			end
			S_CELL: begin
				cmd.sweep = 1'b1;
				if (sts.x_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = sts.y_last ? S_LOOK : S_ROW0;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rdy && sts.req_valid)
				busy_q <= 1'b1;
			else if (cmd.fire)
				busy_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rdy && sts.req_valid |=> state_q != S_IDLE)
		else $error("request accepted but controller stayed idle");
	a_resp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && !sts.out_free |=> state_q == S_RESP)
		else $error("response dropped while output register busy");
`endif
endmodule
`default_nettype wire

>>> sv/lat_dp.sv
// Datapath: config registers, live row banks, age memory, neighbor count and output register.
`default_nettype none
module lat_dp
	import lat_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D,
	parameter int AGE_BITS   = AGE_BITS_D
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	lat_req_if.sink                req,
	lat_rsp_if.source              rsp,
	input  wire cmd_t              cmd,
	output sts_t                   sts
);
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int AW  = XW + YW;
	localparam int AD  = MAX_HEIGHT << XW;
	localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
	localparam int HCW = (HW > CFG_W) ? HW : CFG_W;
	localparam int XCW = (WW > CX_W) ? WW : CX_W;
	localparam int YCW = (HW > CY_W) ? HW : CY_W;

	function automatic logic [WW-1:0] eff_w_f(input logic [CFG_W-1:0] v);
		logic [WCW-1:0] e;
		e = WCW'(v);
		if (e == '0)
			return WW'(1);
		else if (e > WCW'(MAX_WIDTH))
			return WW'(MAX_WIDTH);
		else
			return WW'(e);
	endfunction

	function automatic logic [HW-1:0] eff_h_f(input logic [CFG_W-1:0] v);
		logic [HCW-1:0] e;
		e = HCW'(v);
		if (e == '0)
			return HW'(1);
		else if (e > HCW'(MAX_HEIGHT))
			return HW'(MAX_HEIGHT);
		else
			return HW'(e);
	endfunction

	logic [CFG_W-1:0] gw_q, gh_q;
	logic [WW-1:0]    ew;
	logic [HW-1:0]    eh;
	logic             pend_q;
	logic [AW-1:0]    ctr_q;
	logic [GEN_W-1:0] gen_q;
	logic             bank_q;

	logic [ACT_W-1:0] act_q;
	logic [CX_W-1:0]  ix_q;
	logic [CY_W-1:0]  iy_q;
	logic             alive_q;
	logic [XW-1:0]    xi;
	logic [YW-1:0]    yi;
	logic             in_grid;

	logic [YW-1:0]        y_q, ym, yp;
	logic [XW-1:0]        xs_q, xm, xp;
	logic [MAX_WIDTH-1:0] rp_q, rc_q, rn_q, nrow_q;
	logic [CNT_W-1:0]     ncnt;
	logic                 nb;

	logic                v_s1, nb_s1, ol_s1;
	logic [XW-1:0]       x_s1;
	logic [AGE_BITS-1:0] age_nx;

	logic [MAX_WIDTH-1:0] rd0, rd1, row_rd, row_mod, row_wd;
	logic [YW-1:0]        row_ra, row_wa;
	logic                 row_re, we0, we1;
	logic [AGE_BITS-1:0]  age_rd, age_wd, set_age;
	logic [AW-1:0]        age_ra, age_wa;
	logic                 age_re, age_we;
	logic                 set_ok, cur_live, take;

	logic                 ov_q, oa_q;
	logic [AGE_W-1:0]     oage_q;
	logic [GEN_W-1:0]     ogen_q;

	assign ew = eff_w_f(gw_q);
	assign eh = eff_h_f(gh_q);

	assign take      = cmd.rdy && req.valid;
	assign req.ready = cmd.rdy;

	assign xi      = XW'(ix_q);
	assign yi      = YW'(iy_q);
	assign in_grid = (XCW'(ix_q) < XCW'(ew)) && (YCW'(iy_q) < YCW'(eh));

	assign ym = (y_q == '0) ? YW'(eh - HW'(1)) : y_q - YW'(1);
	assign yp = (HW'(y_q) + HW'(1) == eh) ? '0 : y_q + YW'(1);
	assign xm = (xs_q == '0) ? XW'(ew - WW'(1)) : xs_q - XW'(1);
	assign xp = (WW'(xs_q) + WW'(1) == ew) ? '0 : xs_q + XW'(1);

	assign ncnt = CNT_W'(rp_q[xm]) + CNT_W'(rp_q[xs_q]) + CNT_W'(rp_q[xp])
		+ CNT_W'(rc_q[xm]) + CNT_W'(rc_q[xp])
		+ CNT_W'(rn_q[xm]) + CNT_W'(rn_q[xs_q]) + CNT_W'(rn_q[xp]);
	assign nb = rc_q[xs_q] ? (ncnt inside {SURVIVE_N, BIRTH_N}) : (ncnt == BIRTH_N);

	assign row_rd = bank_q ? rd1 : rd0;
	assign age_nx = (nb_s1 && ol_s1) ? ((&age_rd) ? age_rd : age_rd + AGE_BITS'(1)) : '0;

	assign cur_live = row_rd[xi];
	assign set_ok   = cmd.fire && (act_q == ACT_SET) && in_grid;
	assign set_age  = (alive_q && cur_live) ? age_rd : '0;

	always_comb begin
		row_mod     = row_rd;
		row_mod[xi] = alive_q;
	end

	always_comb begin
		if (cmd.rd_prev)
			row_ra = ym;
		else if (cmd.rd_cur || cmd.rd_next)
			row_ra = cmd.rd_cur ? y_q : yp;
		else
			row_ra = yi;
		row_re = cmd.rd_prev || cmd.rd_cur || cmd.rd_next || cmd.look;

		if (cmd.clr_step) begin
			row_wa = ctr_q[AW-1:XW];
			row_wd = '0;
		end else if (cmd.drain) begin
			row_wa = y_q;
			row_wd = nrow_q;
		end else begin
			row_wa = yi;
			row_wd = row_mod;
		end
		we0 = cmd.clr_step || (cmd.drain && bank_q) || (set_ok && !bank_q);
		we1 = cmd.clr_step || (cmd.drain && !bank_q) || (set_ok && bank_q);

		age_re = cmd.sweep || cmd.look;
		age_ra = cmd.sweep ? {y_q, xs_q} : {yi, xi};
		age_we = cmd.clr_step || v_s1 || set_ok;
		if (cmd.clr_step) begin
			age_wa = ctr_q;
			age_wd = '0;
		end else if (v_s1) begin
			age_wa = {y_q, x_s1};
			age_wd = age_nx;
		end else begin
			age_wa = {yi, xi};
			age_wd = set_age;
		end
	end

	lat_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_live0 (
		.clk(clk), .we(we0), .waddr(row_wa), .wdata(row_wd),
		.re(row_re), .raddr(row_ra), .rdata(rd0)
	);

	lat_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_live1 (
		.clk(clk), .we(we1), .waddr(row_wa), .wdata(row_wd),
		.re(row_re), .raddr(row_ra), .rdata(rd1)
	);

	lat_ram #(.WIDTH(AGE_BITS), .DEPTH(AD)) u_age (
		.clk(clk), .we(age_we), .waddr(age_wa), .wdata(age_wd),
		.re(age_re), .raddr(age_ra), .rdata(age_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q   <= GRID_RESET;
			gh_q   <= GRID_RESET;
			pend_q <= 1'b1;
			ctr_q  <= '0;
			gen_q  <= '0;
			bank_q <= 1'b0;
			v_s1   <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep;
			if (cmd.clr_step) begin
				if (sts.clr_last) begin
					ctr_q  <= '0;
					pend_q <= 1'b0;
					gen_q  <= '0;
				end else begin
					ctr_q <= ctr_q + AW'(1);
				end
			end
			if (cmd.drain && sts.y_last) begin
				bank_q <= !bank_q;
				gen_q  <= gen_q + GEN_W'(1);
			end
			if (cfg_we) begin
				if (cfg_idx == REG_WIDTH) begin
					gw_q <= cfg_wdata;
					if (eff_w_f(cfg_wdata) != ew)
						pend_q <= 1'b1;
				end else begin
					gh_q <= cfg_wdata;
					if (eff_h_f(cfg_wdata) != eh)
						pend_q <= 1'b1;
				end
			end
			if (cmd.fire)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			act_q   <= req.action;
			ix_q    <= req.cell_x;
			iy_q    <= req.cell_y;
			alive_q <= req.alive_in;
		end
		if (cmd.y_zero)
			y_q <= '0;
		else if (cmd.drain && !sts.y_last)
			y_q <= y_q + YW'(1);
		if (cmd.rd_cur)
			rp_q <= row_rd;
		if (cmd.rd_next)
			rc_q <= row_rd;
		if (cmd.cap_next) begin
			rn_q   <= row_rd;
			nrow_q <= '0;
			xs_q   <= '0;
		end
		if (cmd.sweep) begin
			nrow_q[xs_q] <= nb;
			xs_q         <= xs_q + XW'(1);
			x_s1         <= xs_q;
			nb_s1        <= nb;
			ol_s1        <= rc_q[xs_q];
		end
		if (cmd.fire) begin
			ogen_q <= gen_q;
			if (!in_grid) begin
				oa_q   <= 1'b0;
				oage_q <= '0;
			end else if (act_q == ACT_SET) begin
				oa_q   <= alive_q;
				oage_q <= AGE_W'(set_age);
			end else begin
				oa_q   <= cur_live;
				oage_q <= AGE_W'(age_rd);
			end
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.cell_alive = oa_q;
	assign rsp.cell_age   = oage_q;
	assign rsp.gen_number = ogen_q;

	always_comb begin
		sts           = '0;
		sts.pend      = pend_q;
		sts.clr_last  = (ctr_q == AW'(AD - 1));
		sts.req_valid = req.valid;
		sts.req_act   = req.action;
		sts.x_last    = (WW'(xs_q) + WW'(1) == ew);
		sts.y_last    = (HW'(y_q) + HW'(1) == eh);
		sts.out_free  = !ov_q || rsp.ready;
	end

`ifndef SYNTHESIS
	a_clear_zeroes_gen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step && sts.clr_last && !cmd.drain |=> gen_q == '0)
		else $error("generation count not zero after clear pass");
	a_pend_only_by_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pend_q) |-> $past(cmd.clr_step))
		else $error("pending clear dropped without a clear pass");
`endif
endmodule
`default_nettype wire

>>> sv/life_automaton_torus_with_ages_unit.sv
// Top level of the toroidal life automaton with per-cell ages.
`default_nettype none
// Each request sets or clears one cell, advances one generation, clears the grid or only
// queries, and gives one response with the addressed cell's live bit, age and the generation
// count. An advance sweeps the grid in use one cell per cycle, with per-row steps around
// the sweep (three row reads from the live bank, fill and write-back); the age memory's
// single read port sets that rate. A clear request, reset, and any size register write
// that changes the grid in effect run a clearing pass over MAX_HEIGHT * 2**clog2(MAX_WIDTH)
// age entries (4096 by default), during which no request is taken. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module life_automaton_torus_with_ages_unit
	import lat_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D,
	parameter int AGE_BITS   = AGE_BITS_D
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	lat_req_if.sink                req,
	lat_rsp_if.source              rsp
);
	cmd_t cmd;
	sts_t sts;

	lat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	lat_dp #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AGE_BITS(AGE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp), .cmd(cmd), .sts(sts)
	);
endmodule
`default_nettype wire

>>> sim/tb_life_automaton_torus_with_ages_unit.sv
// Testbench for the toroidal life automaton: directed and random requests checked against a local grid model.
module tb_life_automaton_torus_with_ages_unit;
	import lat_pkg::*;

	localparam int GRID_W     = 64;
	localparam int GRID_H     = 64;
	localparam int AGE_SAT    = 65535;
	localparam int IDLE_LIMIT = 200000;

	typedef enum int {MODE_FLOW, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH} pace_t;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [CX_W-1:0]  x;
		logic [CY_W-1:0]  y;
		logic             alive;
	} cell_req_t;

	typedef struct {
		logic             alive;
		logic [AGE_W-1:0] age;
		logic [GEN_W-1:0] gen;
	} cell_rsp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;

	lat_req_if req_ch();
	lat_rsp_if rsp_ch();

	life_automaton_torus_with_ages_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .req(req_ch), .rsp(rsp_ch)
	);

	cell_req_t pending_q[$];
	cell_rsp_t cell_expect_q[$];
	pace_t     pace;
	int        errors;
	int        idle_cycles;
	int        hold_ask;
	int        hold_seen;
	int        hold_left;
	bit        req_taken;

	logic             grid_live[GRID_W*GRID_H];
	logic [AGE_W-1:0] grid_age[GRID_W*GRID_H];
	logic             next_live[GRID_W*GRID_H];
	logic [GEN_W-1:0] gen_ctr;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;

	function automatic int eff_size(logic [CFG_W-1:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic int wrap(int c, int d, int n);
		if (d < 0) return (c == 0) ? n - 1 : c - 1;
		if (d > 0) return (c + 1 >= n) ? 0 : c + 1;
		return c;
	endfunction

	task automatic wipe_grid();
		for (int i = 0; i < GRID_W*GRID_H; i++) begin
			grid_live[i] = 0;
			grid_age[i] = 0;
		end
		gen_ctr = 0;
	endtask

	task automatic life_advance();
		int w, h, n, i;
		w = eff_size(width_reg, GRID_W);
		h = eff_size(height_reg, GRID_H);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if ((dx != 0 || dy != 0) &&
								grid_live[wrap(y, dy, h)*GRID_W + wrap(x, dx, w)])
							n++;
				i = y*GRID_W + x;
				next_live[i] = grid_live[i] ? (n == SURVIVE_N || n == BIRTH_N) : (n == BIRTH_N);
			end
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				i = y*GRID_W + x;
				if (next_live[i] && grid_live[i])
					grid_age[i] = (grid_age[i] == AGE_SAT) ? grid_age[i] : grid_age[i] + 1;
				else
					grid_age[i] = 0;
				grid_live[i] = next_live[i];
			end
		gen_ctr = gen_ctr + 1;
	endtask

	task automatic predict_cell(cell_req_t r);
		cell_rsp_t e;
		int i;
		bit in_grid;
		if (r.act == ACT_STEP) life_advance();
		else if (r.act == ACT_CLEAR) wipe_grid();
		in_grid = (r.x < eff_size(width_reg, GRID_W)) && (r.y < eff_size(height_reg, GRID_H));
		i = r.y*GRID_W + r.x;
		if (r.act == ACT_SET && in_grid) begin
			if (r.alive) begin
				if (!grid_live[i]) grid_age[i] = 0;
				grid_live[i] = 1;
			end else begin
				grid_live[i] = 0;
				grid_age[i] = 0;
			end
		end
		e.alive = in_grid ? grid_live[i] : 1'b0;
		e.age = in_grid ? grid_age[i] : '0;
		e.gen = gen_ctr;
		cell_expect_q.push_back(e);
	endtask

	task automatic report(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", field, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		if (!req_ch.valid || req_taken) begin
			if (pending_q.size() > 0 &&
					!((pace == MODE_SRC_IDLE && $urandom_range(99) < 57) ||
					  (pace == MODE_BOTH && $urandom_range(99) < 9))) begin
				req_ch.action   <= pending_q[0].act;
				req_ch.cell_x   <= pending_q[0].x;
				req_ch.cell_y   <= pending_q[0].y;
				req_ch.alive_in <= pending_q[0].alive;
				void'(pending_q.pop_front());
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		req_taken = 0;
	end

	// response receiver pacing
	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (pace == MODE_SNK_STALL) begin
			rsp_ch.ready <= ($urandom_range(99) >= 57);
		end else if (pace == MODE_BOTH) begin
			rsp_ch.ready <= ($urandom_range(99) >= 9);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		cell_req_t r;
		cell_rsp_t e;
		bit moved;
		moved = 0;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			r.act = req_ch.action;
			r.x = req_ch.cell_x;
			r.y = req_ch.cell_y;
			r.alive = req_ch.alive_in;
			predict_cell(r);
			req_taken = 1;
			moved = 1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			moved = 1;
			if (cell_expect_q.size() == 0) begin
				$display("response with no request outstanding");
				errors++;
			end else begin
				e = cell_expect_q.pop_front();
				if (rsp_ch.cell_alive !== e.alive) report("cell_alive", rsp_ch.cell_alive, e.alive);
				if (rsp_ch.cell_age !== e.age) report("cell_age", rsp_ch.cell_age, e.age);
				if (rsp_ch.gen_number !== e.gen) report("gen_number", rsp_ch.gen_number, e.gen);
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send(logic [ACT_W-1:0] act, int x, int y, int alive);
		cell_req_t r;
		r.act = act;
		r.x = CX_W'(x);
		r.y = CY_W'(y);
		r.alive = (alive != 0);
		pending_q.push_back(r);
	endtask

	task automatic wait_quiet();
		while (pending_q.size() > 0 || cell_expect_q.size() > 0 || req_ch.valid)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CIDX_W-1:0] idx, int val);
		int ow, oh;
		wait_quiet();
		ow = eff_size(width_reg, GRID_W);
		oh = eff_size(height_reg, GRID_H);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = CFG_W'(val);
		if (idx == REG_WIDTH) width_reg = CFG_W'(val);
		else height_reg = CFG_W'(val);
		if (eff_size(width_reg, GRID_W) != ow || eff_size(height_reg, GRID_H) != oh)
			wipe_grid();
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_phase(pace_t p, int count);
		int w, h;
		pace = p;
		w = $urandom_range(1, 8);
		h = $urandom_range(1, 8);
		cfg_write(REG_WIDTH, ($urandom_range(9) == 0) ? (w == 1 ? 0 : w) : w);
		cfg_write(REG_HEIGHT, h);
		w = eff_size(width_reg, GRID_W);
		h = eff_size(height_reg, GRID_H);
		for (int k = 0; k < count; k++) begin
			int pick;
			pick = $urandom_range(99);
			if (pick < 40)
				send(ACT_SET, $urandom_range(w-1), $urandom_range(h-1), $urandom_range(9) < 7);
			else if (pick < 65)
				send(ACT_STEP, $urandom_range(63), $urandom_range(63), $urandom_range(1));
			else if (pick < 85)
				send(ACT_QUERY, $urandom_range(w-1), $urandom_range(h-1), $urandom_range(1));
			else if (pick < 90)
				send(ACT_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(1));
			else
				send(pick < 95 ? ACT_SET : ACT_QUERY, $urandom_range(63), $urandom_range(63),
					$urandom_range(1));
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_ask = 0;
		hold_seen = 0;
		hold_left = 0;
		req_taken = 0;
		pace = MODE_FLOW;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = REG_WIDTH;
		cfg_wdata = '0;
		req_ch.valid = 0;
		req_ch.action = ACT_QUERY;
		req_ch.cell_x = '0;
		req_ch.cell_y = '0;
		req_ch.alive_in = 0;
		rsp_ch.ready = 0;
		width_reg = GRID_RESET;
		height_reg = GRID_RESET;
		wipe_grid();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// full grid: corners, wrap-around neighbors, one advance
		send(ACT_SET, 0, 0, 1);
		send(ACT_SET, 63, 63, 1);
		send(ACT_SET, 63, 0, 1);
		send(ACT_SET, 0, 63, 0);
		send(ACT_SET, 63, 63, 1);
		send(ACT_STEP, 0, 63, 0);
		send(ACT_QUERY, 63, 63, 1);
		send(ACT_QUERY, 0, 0, 0);

		// 3x3 torus: blinker covers everything, tiny grid counts
		cfg_write(REG_WIDTH, 3);
		cfg_write(REG_HEIGHT, 3);
		send(ACT_SET, 1, 0, 1);
		send(ACT_SET, 1, 1, 1);
		send(ACT_SET, 1, 2, 1);
		send(ACT_SET, 1, 1, 1);
		send(ACT_STEP, 1, 1, 0);
		send(ACT_SET, 5, 1, 1);
		send(ACT_QUERY, 0, 3, 1);
		send(ACT_CLEAR, 1, 1, 0);

		// zero acts as one, oversize acts as maximum
		cfg_write(REG_WIDTH, 0);
		cfg_write(REG_HEIGHT, 2);
		send(ACT_SET, 0, 1, 1);
		send(ACT_STEP, 0, 1, 1);
		send(ACT_STEP, 0, 0, 0);
		cfg_write(REG_WIDTH, 127);
		cfg_write(REG_HEIGHT, 1);
		send(ACT_SET, 63, 0, 1);
		send(ACT_STEP, 63, 0, 0);
		send(ACT_QUERY, 63, 1, 1);

		random_phase(MODE_FLOW, 30);
		random_phase(MODE_SRC_IDLE, 30);
		random_phase(MODE_SNK_STALL, 30);
		hold_ask++;
		random_phase(MODE_BOTH, 30);
		wait_quiet();
		pace = MODE_FLOW;
		repeat (50) @(negedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
